FILE: rtl/bsfw_pkg.sv
`timescale 1ns / 1ps

package bsfw_pkg;

	localparam int FREE_W     = 16;
	localparam int FIT_W      = 16;
	localparam int ORIGIN_W   = 10;
	localparam int ORIGIN_SAT = 1023;
	localparam int GW_REG_W   = 5;
	localparam int SH_REG_W   = 3;
	localparam int SW_REG_W   = 5;
	localparam int SROW_W     = 16;
	localparam int SHAPE_REGS = 4;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 5;

	localparam int GRID_COLS_MAX_DEF  = 16;
	localparam int SHAPE_ROWS_MAX_DEF = 4;
	localparam int MAX_ROWS_DEF       = 1024;

	localparam logic [GW_REG_W-1:0] GRID_WIDTH_RST   = 5'd16;
	localparam logic [SH_REG_W-1:0] SHAPE_HEIGHT_RST = 3'd1;
	localparam logic [SW_REG_W-1:0] SHAPE_WIDTH_RST  = 5'd1;

	typedef enum logic [2:0] {
		REG_GRID_WIDTH   = 3'd0,
		REG_SHAPE_HEIGHT = 3'd1,
		REG_SHAPE_WIDTH  = 3'd2,
		REG_SHAPE_ROW_A  = 3'd3,
		REG_SHAPE_ROW_B  = 3'd4,
		REG_SHAPE_ROW_C  = 3'd5,
		REG_SHAPE_ROW_D  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic                full;
		logic [ORIGIN_W-1:0] origin;
	} win_stat_t;

endpackage

FILE: rtl/bsfw_lane.sv
`timescale 1ns / 1ps

module bsfw_lane import bsfw_pkg::*; #(
	parameter int LANE_IDX = 0,
	parameter int SR_ROWS  = 4,
	parameter int GW_W     = 5
) (
	input  logic [FREE_W-1:0]   win [SR_ROWS],
	input  logic [SROW_W-1:0]   sr  [SR_ROWS],
	input  logic [SW_REG_W-1:0] shape_width,
	input  logic [GW_W-1:0]     gw_sat,
	output logic                fit
);

	always_comb begin
		fit = ((LANE_IDX + int'(shape_width)) <= int'(gw_sat));
		for (int i = 0; i < SR_ROWS; i++) begin
			if (((win[i] >> LANE_IDX) & sr[i]) != sr[i]) begin
				fit = 1'b0;
			end
		end
	end

endmodule

FILE: rtl/bsfw_window.sv
`timescale 1ns / 1ps

module bsfw_window import bsfw_pkg::*; #(
	parameter int SHAPE_ROWS_MAX = SHAPE_ROWS_MAX_DEF,
	parameter int MAX_ROWS       = MAX_ROWS_DEF,
	localparam int HS_W    = $clog2(SHAPE_ROWS_MAX + 1),
	localparam int SR_ROWS = (SHAPE_ROWS_MAX < SHAPE_REGS) ? SHAPE_ROWS_MAX : SHAPE_REGS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [FREE_W-1:0] free_cells,
	input  logic              first_row,
	input  logic [HS_W-1:0]   h_sat,
	input  logic [FREE_W-1:0] col_mask,
	output logic [FREE_W-1:0] win [SR_ROWS],
	output win_stat_t         stat
);

	localparam int HIST_D = (SHAPE_ROWS_MAX > 1) ? SHAPE_ROWS_MAX - 1 : 1;
	localparam int CNT_W  = $clog2(MAX_ROWS + 1);

	logic [FREE_W-1:0] hist_q   [HIST_D];
	logic [FREE_W-1:0] hist_eff [HIST_D];
	logic [FREE_W-1:0] rows_all [SHAPE_ROWS_MAX];
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_eff;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [CNT_W-1:0]  org;

	always_comb begin
		for (int k = 0; k < HIST_D; k++) begin
			hist_eff[k] = first_row ? '0 : hist_q[k];
		end
		cnt_eff = first_row ? '0 : cnt_q;
		cnt_nxt = (int'(cnt_eff) < MAX_ROWS) ? cnt_eff + CNT_W'(1) : cnt_eff;
	end

	always_comb begin
		rows_all[0] = free_cells;
		for (int b = 1; b < SHAPE_ROWS_MAX; b++) begin
			rows_all[b] = hist_eff[b-1];
		end
		for (int i = 0; i < SR_ROWS; i++) begin
			win[i] = '0;
			for (int b = 0; b < SHAPE_ROWS_MAX; b++) begin
				if ((i + b < SHAPE_ROWS_MAX) && (HS_W'(i + b + 1) == h_sat)) begin
					win[i] = rows_all[b] & col_mask;
				end
			end
		end
	end

	always_comb begin
		org         = cnt_nxt - CNT_W'(h_sat);
		stat.full   = (h_sat != '0) && (cnt_nxt >= CNT_W'(h_sat));
		stat.origin = '0;
		if (stat.full) begin
			if (int'(org) > ORIGIN_SAT) begin
				stat.origin = ORIGIN_W'(ORIGIN_SAT);
			end else begin
				stat.origin = ORIGIN_W'(org);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int k = 0; k < HIST_D; k++) begin
				hist_q[k] <= '0;
			end
		end else if (accept) begin
			cnt_q     <= cnt_nxt;
			hist_q[0] <= free_cells;
			for (int k = 1; k < HIST_D; k++) begin
				hist_q[k] <= hist_eff[k-1];
			end
		end
	end

endmodule

FILE: rtl/binary_shape_fit_window_unit.sv
`timescale 1ns / 1ps

// binary shape fit window unit
// input channel: row_valid / row_ready carry one grid row per beat
//   (free_cells, first_row); first_row starts a new grid
// output channel: fit_valid / fit_ready carry one result beat per row
//   (window_full, origin_row, fit_mask)
// one lane per column offset tests the shape against the row window in the
//   cycle the row is taken; the lane results are merged into fit_mask
// output register: the result is registered as the row beat is accepted
// throughput: one row per cycle, sustained while fit_ready stays high
// stall: while a result waits and fit_ready is low, row_ready is low; a new
//   row is taken in the same cycle the waiting result leaves
// configuration: apb writes at byte address 4*i, reads return the register
// reset: arst_n clears the registers to their defaults, empties the output
//   register and starts a new grid
module binary_shape_fit_window_unit import bsfw_pkg::*; #(
	parameter int GRID_COLS_MAX  = GRID_COLS_MAX_DEF,
	parameter int SHAPE_ROWS_MAX = SHAPE_ROWS_MAX_DEF,
	parameter int MAX_ROWS       = MAX_ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                row_valid,
	output logic                row_ready,
	input  logic [FREE_W-1:0]   free_cells,
	input  logic                first_row,
	output logic                fit_valid,
	input  logic                fit_ready,
	output logic                window_full,
	output logic [ORIGIN_W-1:0] origin_row,
	output logic [FIT_W-1:0]    fit_mask
);

	localparam int HS_W    = $clog2(SHAPE_ROWS_MAX + 1);
	localparam int GW_W    = $clog2(GRID_COLS_MAX + 1);
	localparam int SR_ROWS = (SHAPE_ROWS_MAX < SHAPE_REGS) ? SHAPE_ROWS_MAX : SHAPE_REGS;
	localparam int LANES   = (GRID_COLS_MAX < FIT_W) ? GRID_COLS_MAX : FIT_W;

	logic [GW_REG_W-1:0] grid_width_q;
	logic [SH_REG_W-1:0] shape_height_q;
	logic [SW_REG_W-1:0] shape_width_q;
	logic [SROW_W-1:0]   shape_row_q [SHAPE_REGS];

	logic                wr_en;
	reg_idx_t            reg_idx;
	logic [HS_W-1:0]     h_sat;
	logic [GW_W-1:0]     gw_sat;
	logic [FREE_W-1:0]   col_mask;
	logic [SROW_W-1:0]   sw_mask;
	logic [SROW_W-1:0]   sr [SR_ROWS];
	logic                any_star;
	logic                cfg_ok;
	logic [FREE_W-1:0]   win [SR_ROWS];
	win_stat_t           stat;
	logic [LANES-1:0]    lane_fit;
	logic [FIT_W-1:0]    fit_all;
	logic                accept;

	logic                fit_valid_q;
	logic                window_full_q;
	logic [ORIGIN_W-1:0] origin_row_q;
	logic [FIT_W-1:0]    fit_mask_q;

	// config port
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q   <= GRID_WIDTH_RST;
			shape_height_q <= SHAPE_HEIGHT_RST;
			shape_width_q  <= SHAPE_WIDTH_RST;
			for (int i = 0; i < SHAPE_REGS; i++) begin
				shape_row_q[i] <= '0;
			end
		end else if (wr_en) begin
			case (reg_idx)
				REG_GRID_WIDTH:   grid_width_q   <= pwdata[GW_REG_W-1:0];
				REG_SHAPE_HEIGHT: shape_height_q <= pwdata[SH_REG_W-1:0];
				REG_SHAPE_WIDTH:  shape_width_q  <= pwdata[SW_REG_W-1:0];
				REG_SHAPE_ROW_A:  shape_row_q[0] <= pwdata[SROW_W-1:0];
				REG_SHAPE_ROW_B:  shape_row_q[1] <= pwdata[SROW_W-1:0];
				REG_SHAPE_ROW_C:  shape_row_q[2] <= pwdata[SROW_W-1:0];
				REG_SHAPE_ROW_D:  shape_row_q[3] <= pwdata[SROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GRID_WIDTH:   prdata = DATA_W'(grid_width_q);
			REG_SHAPE_HEIGHT: prdata = DATA_W'(shape_height_q);
			REG_SHAPE_WIDTH:  prdata = DATA_W'(shape_width_q);
			REG_SHAPE_ROW_A:  prdata = DATA_W'(shape_row_q[0]);
			REG_SHAPE_ROW_B:  prdata = DATA_W'(shape_row_q[1]);
			REG_SHAPE_ROW_C:  prdata = DATA_W'(shape_row_q[2]);
			REG_SHAPE_ROW_D:  prdata = DATA_W'(shape_row_q[3]);
			default:          prdata = '0;
		endcase
	end

	// shape setup from config
	always_comb begin
		if (int'(shape_height_q) > SHAPE_ROWS_MAX) begin
			h_sat = HS_W'(SHAPE_ROWS_MAX);
		end else begin
			h_sat = HS_W'(shape_height_q);
		end
		if (int'(grid_width_q) > GRID_COLS_MAX) begin
			gw_sat = GW_W'(GRID_COLS_MAX);
		end else begin
			gw_sat = GW_W'(grid_width_q);
		end
		for (int c = 0; c < FREE_W; c++) begin
			col_mask[c] = (c < int'(gw_sat));
		end
		for (int c = 0; c < SROW_W; c++) begin
			sw_mask[c] = (c < int'(shape_width_q));
		end
		any_star = 1'b0;
		for (int i = 0; i < SR_ROWS; i++) begin
			sr[i]    = (i < int'(h_sat)) ? (shape_row_q[i] & sw_mask) : '0;
			any_star = any_star | (|sr[i]);
		end
		cfg_ok = any_star && (int'(shape_width_q) <= int'(gw_sat));
	end

	assign row_ready = !fit_valid_q || fit_ready;
	assign accept    = row_valid && row_ready;

	bsfw_window #(
		.SHAPE_ROWS_MAX (SHAPE_ROWS_MAX),
		.MAX_ROWS       (MAX_ROWS)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.free_cells (free_cells),
		.first_row  (first_row),
		.h_sat      (h_sat),
		.col_mask   (col_mask),
		.win        (win),
		.stat       (stat)
	);

	for (genvar z = 0; z < LANES; z++) begin : g_lane
		bsfw_lane #(
			.LANE_IDX (z),
			.SR_ROWS  (SR_ROWS),
			.GW_W     (GW_W)
		) u_lane (
			.win         (win),
			.sr          (sr),
			.shape_width (shape_width_q),
			.gw_sat      (gw_sat),
			.fit         (lane_fit[z])
		);
	end

	// merge lanes
	always_comb begin
		fit_all = '0;
		if (stat.full && cfg_ok) begin
			fit_all[LANES-1:0] = lane_fit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_valid_q <= 1'b0;
		end else if (accept) begin
			fit_valid_q <= 1'b1;
		end else if (fit_ready) begin
			fit_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			window_full_q <= stat.full;
			origin_row_q  <= stat.origin;
			fit_mask_q    <= fit_all;
		end
	end

	assign fit_valid   = fit_valid_q;
	assign window_full = window_full_q;
	assign origin_row  = origin_row_q;
	assign fit_mask    = fit_mask_q;

endmodule

FILE: rtl/bsfw_checker.sv
`timescale 1ns / 1ps

module bsfw_checker import bsfw_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                row_valid,
	input logic                row_ready,
	input logic                fit_valid,
	input logic                fit_ready,
	input logic                window_full,
	input logic [ORIGIN_W-1:0] origin_row,
	input logic [FIT_W-1:0]    fit_mask
);

	// result beat holds while stalled
	a_fit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fit_valid && !fit_ready |=> fit_valid)
		else $error("result beat dropped while stalled");

	a_fit_stable: assert property (@(posedge clk) disable iff (!arst_n)
		fit_valid && !fit_ready |=>
			$stable(window_full) && $stable(origin_row) && $stable(fit_mask))
		else $error("stalled result beat changed");

	// every accepted row yields a result next cycle
	a_row_result: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_ready |=> fit_valid)
		else $error("accepted row gave no result");

	// no fits or origin before the window fills
	a_not_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fit_valid && !window_full |-> origin_row == '0 && fit_mask == '0)
		else $error("fits reported before window full");

endmodule

bind binary_shape_fit_window_unit bsfw_checker u_bsfw_checker (.*);

FILE: test/bsfw_fit_checker.sv
`timescale 1ns / 1ps

module bsfw_fit_checker import bsfw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	input  logic                row_valid,
	input  logic                row_ready,
	input  logic [FREE_W-1:0]   free_cells,
	input  logic                first_row,
	input  logic                fit_valid,
	input  logic                fit_ready,
	input  logic                window_full,
	input  logic [ORIGIN_W-1:0] origin_row,
	input  logic [FIT_W-1:0]    fit_mask,
	output int                  fail_count,
	output int                  pending
);

	typedef struct packed {
		win_stat_t        stat;
		logic [FIT_W-1:0] fits;
	} fit_beat_t;

	logic [GW_REG_W-1:0] grid_w;
	logic [SH_REG_W-1:0] shape_h;
	logic [SW_REG_W-1:0] shape_w;
	logic [SROW_W-1:0]   shape_rows [SHAPE_REGS];
	logic [FREE_W-1:0]   prev_rows [3];
	int                  rows_seen;
	fit_beat_t           pending_fits [$];

	task automatic report_mismatch(input string field, input int got_v, input int want_v);
		$display("%0t ns: %s got %0h expected %0h", $time, field, got_v, want_v);
		fail_count++;
	endtask

	// erosion of the row window by the shape, bottom shape row on cur
	function automatic fit_beat_t erode_row(input logic [FREE_W-1:0] cur);
		fit_beat_t        r;
		int               gw_eff, h, w, org, back, i, z;
		logic [31:0]      gmask, smask;
		logic [FREE_W-1:0] win [SHAPE_REGS];
		logic [SROW_W-1:0] star;
		logic             any_star, ok;
		r = '0;
		gw_eff = (grid_w > GRID_COLS_MAX_DEF) ? GRID_COLS_MAX_DEF : int'(grid_w);
		h = (shape_h > SHAPE_ROWS_MAX_DEF) ? SHAPE_ROWS_MAX_DEF : int'(shape_h);
		w = int'(shape_w);
		if (h == 0 || rows_seen < h)
			return r;
		org = rows_seen - h;
		r.stat.full = 1'b1;
		r.stat.origin = (org > ORIGIN_SAT) ? ORIGIN_W'(ORIGIN_SAT) : ORIGIN_W'(org);
		gmask = (32'd1 << gw_eff) - 32'd1;
		smask = (32'd1 << w) - 32'd1;
		any_star = 1'b0;
		for (i = 0; i < h; i++) begin
			back = h - 1 - i;
			win[i] = ((back == 0) ? cur : prev_rows[back-1]) & gmask[FREE_W-1:0];
			any_star |= |(shape_rows[i] & smask[SROW_W-1:0]);
		end
		if (any_star && w <= gw_eff) begin
			for (z = 0; z + w <= gw_eff; z++) begin
				ok = 1'b1;
				for (i = 0; i < h; i++) begin
					star = shape_rows[i] & smask[SROW_W-1:0];
					if (((win[i] >> z) & star) != star)
						ok = 1'b0;
				end
				if (ok)
					r.fits[z] = 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		fit_beat_t got, want;
		if (!arst_n) begin
			grid_w = GRID_WIDTH_RST;
			shape_h = SHAPE_HEIGHT_RST;
			shape_w = SHAPE_WIDTH_RST;
			shape_rows = '{default: '0};
			prev_rows = '{default: '0};
			rows_seen = 0;
			pending_fits.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_GRID_WIDTH:   grid_w = pwdata[GW_REG_W-1:0];
					REG_SHAPE_HEIGHT: shape_h = pwdata[SH_REG_W-1:0];
					REG_SHAPE_WIDTH:  shape_w = pwdata[SW_REG_W-1:0];
					REG_SHAPE_ROW_A:  shape_rows[0] = pwdata[SROW_W-1:0];
					REG_SHAPE_ROW_B:  shape_rows[1] = pwdata[SROW_W-1:0];
					REG_SHAPE_ROW_C:  shape_rows[2] = pwdata[SROW_W-1:0];
					REG_SHAPE_ROW_D:  shape_rows[3] = pwdata[SROW_W-1:0];
					default: ;
				endcase
			end
			if (fit_valid && fit_ready) begin
				got = {window_full, origin_row, fit_mask};
				if (pending_fits.size() == 0) begin
					report_mismatch("result beat with none pending", int'(got), 0);
				end else begin
					want = pending_fits.pop_front();
					if (got.stat.full !== want.stat.full)
						report_mismatch("window_full", got.stat.full, want.stat.full);
					if (got.stat.origin !== want.stat.origin)
						report_mismatch("origin_row", got.stat.origin, want.stat.origin);
					if (got.fits !== want.fits)
						report_mismatch("fit_mask", got.fits, want.fits);
				end
			end
			if (row_valid && row_ready) begin
				if (first_row) begin
					prev_rows = '{default: '0};
					rows_seen = 0;
				end
				if (rows_seen < MAX_ROWS_DEF)
					rows_seen++;
				pending_fits = {pending_fits, erode_row(free_cells)};
				prev_rows[2] = prev_rows[1];
				prev_rows[1] = prev_rows[0];
				prev_rows[0] = free_cells;
			end
			pending <= pending_fits.size();
		end
	end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bsfw_pkg::*;

	localparam int IDLE_LIMIT = 600;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                row_valid = 1'b0;
	logic                row_ready;
	logic [FREE_W-1:0]   free_cells = '0;
	logic                first_row = 1'b0;
	logic                fit_valid;
	logic                fit_ready = 1'b0;
	logic                window_full;
	logic [ORIGIN_W-1:0] origin_row;
	logic [FIT_W-1:0]    fit_mask;

	int fail_count;
	int pending;
	int burst_left = 0;
	int ready_left = 0;
	bit ready_on = 1'b0;
	int idle_cycles = 0;

	binary_shape_fit_window_unit u_dut (.*);

	bsfw_fit_checker u_checker (.*);

	always #5 clk = ~clk;

	// receiver: long ready stretches broken by short stalls
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_on = !ready_on;
			ready_left = ready_on ? $urandom_range(1, 40) : $urandom_range(1, 6);
		end
		ready_left--;
		fit_ready <= ready_on;
	end

	always @(posedge clk) begin
		if (!arst_n || (row_valid && row_ready) || (fit_valid && fit_ready) || (psel && penable))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("binary_shape_fit_window_unit: mismatch");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic send_row(input logic [FREE_W-1:0] cells, input logic first);
		@(negedge clk);
		if (burst_left == 0) begin
			row_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 24);
		end
		row_valid <= 1'b1;
		free_cells <= cells;
		first_row <= first;
		do @(posedge clk); while (!row_ready);
		burst_left--;
	endtask

	// sender holds off until every pending result beat is out
	task automatic drain();
		@(negedge clk);
		row_valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [15:0] val);
		logic [15:0] junk;
		junk = 16'($urandom);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {junk, val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_shape(input int gw, input int sh, input int sw,
			input logic [15:0] ra, input logic [15:0] rb,
			input logic [15:0] rc, input logic [15:0] rd);
		drain();
		apb_write(REG_GRID_WIDTH, 16'(gw));
		apb_write(REG_SHAPE_HEIGHT, 16'(sh));
		apb_write(REG_SHAPE_WIDTH, 16'(sw));
		apb_write(REG_SHAPE_ROW_A, ra);
		apb_write(REG_SHAPE_ROW_B, rb);
		apb_write(REG_SHAPE_ROW_C, rc);
		apb_write(REG_SHAPE_ROW_D, rd);
	endtask

	function automatic logic [FREE_W-1:0] rand_cells();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return FREE_W'($urandom);
			default: return FREE_W'($urandom | $urandom | $urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_stars(input int sw);
		logic [31:0] s;
		s = $urandom & $urandom & $urandom & ((32'd1 << sw) - 32'd1);
		if (sw > 0 && $urandom_range(0, 3) != 0)
			s |= 32'd1 << $urandom_range(0, sw - 1);
		if ($urandom_range(0, 9) == 0)
			s |= $urandom;
		return s[15:0];
	endfunction

	initial begin
		int ph, n, gw, sh, sw, grid_left;
		logic first;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// default shape is empty; rows before any marked top row
		send_row(16'hFFFF, 1'b0);
		send_row(16'h1234, 1'b0);

		// plus sign, fourth row beyond the height
		set_shape(16, 3, 3, 16'h0002, 16'h0007, 16'h0002, 16'hFFFF);
		send_row(16'hFFFF, 1'b1);
		send_row(16'hFFFF, 1'b0);
		send_row(16'hFFFF, 1'b0);
		send_row(16'hFFEF, 1'b0);
		send_row(16'hFFFF, 1'b0);
		send_row(16'h0000, 1'b0);
		send_row(16'hFFFF, 1'b1);
		send_row(16'hFFFF, 1'b0);
		send_row(16'hFFFF, 1'b0);

		// full-size block
		set_shape(16, 4, 16, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_row(16'hFFFF, 1'b1);
		send_row(16'hFFFF, 1'b0);
		send_row(16'hFFFF, 1'b0);
		send_row(16'hFFFF, 1'b0);
		send_row(16'h7FFF, 1'b0);

		// grid width and height saturate
		set_shape(20, 7, 1, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
		send_row(16'h8001, 1'b1);
		send_row(16'h8001, 1'b0);
		send_row(16'h8001, 1'b0);
		send_row(16'hC003, 1'b0);

		// zero height, zero grid width
		set_shape(0, 0, 17, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
		send_row(16'hFFFF, 1'b1);

		// shape wider than grid
		set_shape(8, 2, 9, 16'h0001, 16'h0001, 16'h0000, 16'h0000);
		send_row(16'hFFFF, 1'b1);
		send_row(16'hFFFF, 1'b0);

		// stars beyond the shape width, free bits beyond the grid
		set_shape(8, 2, 2, 16'hFFF1, 16'hFF02, 16'h0000, 16'h0000);
		send_row(16'hFF0F, 1'b1);
		send_row(16'hFF3C, 1'b0);

		// one longer grid with a single-cell shape
		set_shape(16, 1, 1, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
		send_row(rand_cells(), 1'b1);
		repeat (19) send_row(rand_cells(), 1'b0);

		for (ph = 0; ph < 12; ph++) begin
			case ($urandom_range(0, 9))
				0: gw = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) : $urandom_range(17, 31);
				1: gw = 16;
				default: gw = $urandom_range(4, 16);
			endcase
			sh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
			case ($urandom_range(0, 9))
				0: sw = $urandom_range(0, 31);
				1: sw = (gw > 16) ? 16 : gw;
				default: sw = $urandom_range(1, 4);
			endcase
			set_shape(gw, sh, sw, rand_stars(sw), rand_stars(sw), rand_stars(sw),
				rand_stars(sw));
			grid_left = 0;
			for (n = 0; n < 34; n++) begin
				first = 1'b0;
				if (grid_left == 0) begin
					first = ($urandom_range(0, 9) != 0);
					grid_left = $urandom_range(1, 20);
				end else if ($urandom_range(0, 19) == 0)
					first = 1'b1;
				grid_left--;
				send_row(rand_cells(), first);
				if ($urandom_range(0, 49) == 0)
					drain();
			end
		end

		drain();
		repeat (5) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("binary_shape_fit_window_unit: match");
		else
			$display("binary_shape_fit_window_unit: mismatch");
		$finish;
	end

endmodule
